### hw/rtl/prwg_pkg.sv
// Shared types and constants of the path reference window generator.
package prwg_pkg;

    localparam int PATH_DEPTH    = 1024;
    localparam int IDX_W         = 10;
    localparam int LEN_W         = 11;
    localparam int IPS_W         = 23;
    localparam int SEARCH_WINDOW = 10;
    localparam int HORIZON       = 6;
    localparam int STEP_W        = 3;
    localparam int WIN_W         = 4;
    localparam int ENTRY_W       = 128;
    localparam int IN_TDATA_W    = 240;
    localparam int OUT_TDATA_W   = 144;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [0:0] REG_COURSE_LENGTH   = 1'b0;
    localparam logic [0:0] REG_INDEX_PER_SPEED = 1'b1;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic              is_query;
        logic [IDX_W-1:0]  point_index;
        logic [ENTRY_W-1:0] entry;
        logic [31:0]       vehicle_x;
        logic [31:0]       vehicle_y;
        logic [31:0]       speed_abs;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MAG,
        ST_ADV,
        ST_READ,
        ST_FETCH,
        ST_EMIT
    } exec_state_t;

endpackage

### hw/rtl/prwg_ram.sv
// Generic single-port-write, registered-read RAM.
module prwg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### hw/rtl/prwg_front.sv
// Front part: accepts input transfers, classifies them and unpacks fields.
module prwg_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [prwg_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tuser,
    output logic                                q_valid,
    input  logic                                q_ready,
    output prwg_pkg::cmd_t                      q_cmd
);
    import prwg_pkg::*;

    logic [31:0] vspeed;
    cmd_t        cmd;

    assign vspeed = s_tdata[233:202];

    // Unpack and take the speed magnitude
    always_comb begin
        cmd.is_query    = (s_tuser == REQ_QUERY);
        cmd.point_index = s_tdata[9:0];
        cmd.entry       = s_tdata[137:10];
        cmd.vehicle_x   = s_tdata[169:138];
        cmd.vehicle_y   = s_tdata[201:170];
        cmd.speed_abs   = vspeed[31] ? (32'd0 - vspeed) : vspeed;
    end

    // Two-entry queue toward the back part
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       buf_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic       push, pop;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = buf_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
        end
        if (push) begin
            buf_reg[wr_ptr_reg] <= cmd;
        end
    end
endmodule

### hw/rtl/prwg_back.sv
// Back part: table writes, windowed nearest search and horizon reads.
module prwg_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  prwg_pkg::cmd_t                  q_cmd,
    input  logic [prwg_pkg::LEN_W-1:0]      course_length,
    input  logic [prwg_pkg::IPS_W-1:0]      index_per_speed,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [prwg_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    output logic                            busy
);
    import prwg_pkg::*;

    exec_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    logic [IDX_W-1:0] target_reg, target_next;
    logic [IDX_W-1:0] last_idx, start_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] scan_reg, scan_next;    // address being read
    logic [WIN_W-1:0] issued_reg, issued_next; // reads issued
    logic             dvalid_reg;              // read data is for a scan entry
    logic [IDX_W-1:0] didx_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [64:0]      best_d_reg;
    logic             have_best_reg;
    logic [WIN_W-1:0] win_len;
    logic [ENTRY_W-1:0] rd_entry;
    logic [54:0]      mag_reg;
    logic [57:0]      acc_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0] hidx_reg;
    logic             wr_en;
    logic [LEN_W-1:0] len_c;
    logic             ob_full_reg;
    logic [OUT_TDATA_W-1:0] ob_data_reg;
    logic             ob_last_reg;

    // Clamp the course length to 1..PATH_DEPTH
    always_comb begin
        if (course_length == '0) len_c = LEN_W'(1);
        else if (course_length > LEN_W'(PATH_DEPTH)) len_c = LEN_W'(PATH_DEPTH);
        else len_c = course_length;
        last_idx  = IDX_W'(len_c - LEN_W'(1));
        start_idx = (target_reg > last_idx) ? last_idx : target_reg;
        if ({1'b0, start_idx} + LEN_W'(SEARCH_WINDOW) > len_c)
            win_len = WIN_W'(len_c - {1'b0, start_idx});
        else
            win_len = WIN_W'(SEARCH_WINDOW);
    end

    // Table memories, one per field
    assign wr_en = (state_reg == ST_IDLE) && q_valid && !q_cmd.is_query;

    for (genvar f = 0; f < 4; f++) begin : g_tab
        prwg_ram #(.WIDTH(32), .DEPTH(PATH_DEPTH)) u_ram (
            .aclk    (aclk),
            .wr_en   (wr_en),
            .wr_addr (q_cmd.point_index),
            .wr_data (q_cmd.entry[32*f +: 32]),
            .rd_addr (rd_addr),
            .rd_data (rd_entry[32*f +: 32])
        );
    end

    // Squared distance of the entry that came out of the table
    logic signed [32:0] dx, dy;
    logic [32:0] ax, ay;
    logic [63:0] qx_reg, qy_reg;
    logic        qvalid_reg;
    logic [IDX_W-1:0] qidx_reg;
    logic [64:0] dsum;

    assign dx = $signed({rd_entry[31], rd_entry[31:0]})
              - $signed({cmd_reg.vehicle_x[31], cmd_reg.vehicle_x});
    assign dy = $signed({rd_entry[63], rd_entry[63:32]})
              - $signed({cmd_reg.vehicle_y[31], cmd_reg.vehicle_y});
    assign ax = dx[32] ? (33'd0 - dx) : dx;
    assign ay = dy[32] ? (33'd0 - dy) : dy;
    assign dsum = {1'b0, qx_reg} + {1'b0, qy_reg};

    logic scan_done;
    assign scan_done = (issued_reg == win_len) && !dvalid_reg && !qvalid_reg;

    // Next state and outputs of the sequencer
    always_comb begin
        state_next  = state_reg;
        target_next = target_reg;
        scan_next   = scan_reg;
        issued_next = issued_reg;
        step_next   = step_reg;
        q_ready     = 1'b0;
        rd_addr     = scan_reg;
        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid && q_cmd.is_query) begin
                    state_next  = ST_SEARCH;
                    scan_next   = start_idx;
                    issued_next = '0;
                end
            end
            ST_SEARCH: begin
                if (issued_reg != win_len) begin
                    scan_next   = scan_reg + IDX_W'(1);
                    issued_next = issued_reg + WIN_W'(1);
                end
                if (scan_done) begin
                    target_next = best_idx_reg;
                    state_next  = ST_MAG;
                end
            end
            ST_MAG: begin
                step_next  = '0;
                state_next = ST_ADV;
            end
            ST_ADV: begin
                state_next = ST_READ;
            end
            ST_READ: begin
                rd_addr    = hidx_reg;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                rd_addr    = hidx_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                rd_addr = hidx_reg;
                if (!ob_full_reg) begin
                    if (step_reg == STEP_W'(HORIZON - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next  = step_reg + STEP_W'(1);
                        state_next = ST_ADV;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    logic [58:0] adv_sum;
    logic [26:0] adv_int;
    assign adv_sum = {1'b0, acc_reg} + 59'h0_8000_0000;
    assign adv_int = adv_sum[58:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            dvalid_reg    <= 1'b0;
            qvalid_reg    <= 1'b0;
            have_best_reg <= 1'b0;
            ob_full_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            target_reg <= target_next;
            dvalid_reg <= (state_reg == ST_SEARCH) && (issued_reg != win_len);
            qvalid_reg <= dvalid_reg;
            if (state_reg == ST_IDLE) begin
                have_best_reg <= 1'b0;
            end else if (qvalid_reg) begin
                have_best_reg <= 1'b1;
            end
            if (state_reg == ST_EMIT && !ob_full_reg) begin
                ob_full_reg <= 1'b1;
            end else if (m_tready) begin
                ob_full_reg <= 1'b0;
            end
        end
        scan_reg   <= scan_next;
        issued_reg <= issued_next;
        step_reg   <= step_next;
        didx_reg   <= scan_reg;
        qidx_reg   <= didx_reg;
        qx_reg     <= 64'(ax) * 64'(ax);
        qy_reg     <= 64'(ay) * 64'(ay);
        if (state_reg == ST_IDLE && q_valid) begin
            cmd_reg <= q_cmd;
        end
        // Keep the first minimum
        if (qvalid_reg && (!have_best_reg || dsum < best_d_reg)) begin
            best_d_reg   <= dsum;
            best_idx_reg <= qidx_reg;
        end
        if (state_reg == ST_MAG) begin
            mag_reg <= 55'(cmd_reg.speed_abs * 55'(index_per_speed));
            acc_reg <= '0;
        end
        if (state_reg == ST_ADV) begin
            acc_reg <= acc_reg + 58'(mag_reg);
        end
        if (state_reg == ST_READ) begin
            if (adv_int >= 27'(last_idx) ||
                27'(target_reg) + adv_int >= 27'(last_idx))
                hidx_reg <= last_idx;
            else
                hidx_reg <= IDX_W'(27'(target_reg) + adv_int);
        end
        if (state_reg == ST_EMIT && !ob_full_reg) begin
            ob_data_reg <= {3'b0, target_reg, step_reg, rd_entry};
            ob_last_reg <= (step_reg == STEP_W'(HORIZON - 1));
        end
    end

    // The horizon index is set in ST_READ and presented to the table in
    // ST_FETCH; the registered read data is valid in ST_EMIT and holds there
    // because rd_addr stays on hidx_reg.
    assign m_tvalid = ob_full_reg;
    assign m_tdata  = ob_data_reg;
    assign m_tlast  = ob_last_reg;
    assign busy     = (state_reg != ST_IDLE) || q_valid || ob_full_reg;
endmodule

### hw/rtl/path_reference_window_generator.sv
// Top level of the path reference window generator.
// A load transfer (tuser 0) writes one path entry when the back part takes it
// from the queue in ST_IDLE, and loads stream at one per cycle while no query
// is being worked. A query transfer (tuser 1) scans up to ten entries from the
// kept target index through the table read port and a two-stage distance
// pipeline, computes the speed product in ST_MAG, then gives six reference
// results, each through ST_ADV, ST_READ, ST_FETCH and ST_EMIT on the shared
// table read port, with ST_EMIT waiting while the output is stalled. Queries
// are worked one at a time; a two-entry queue decouples the input.
// Configuration is accepted only while nothing is in flight.
module path_reference_window_generator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_index, point_x, point_y, point_heading, point_speed,
    // vehicle_x, vehicle_y, vehicle_speed (lowest first)
    input  logic [239:0] s_tdata,
    input  logic         s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    // ref_x, ref_y, ref_heading, ref_speed, horizon_step, nearest_index
    output logic [143:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [22:0]  cfg_data
);
    import prwg_pkg::*;

    logic             q_valid, q_ready, busy;
    cmd_t             q_cmd;
    logic [LEN_W-1:0] course_length_reg;
    logic [IPS_W-1:0] ips_reg;

    // Configuration registers
    assign cfg_ready = !busy;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            course_length_reg <= LEN_W'(1);
            ips_reg           <= IPS_W'(13107);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_COURSE_LENGTH:   course_length_reg <= cfg_data[LEN_W-1:0];
                REG_INDEX_PER_SPEED: ips_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    prwg_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    prwg_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .course_length(course_length_reg), .index_per_speed(ips_reg),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .busy(busy)
    );

    // Held result stays put while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // Horizon step never passes the last step
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[130:128] <= 3'd5)
        else $error("horizon step out of range");

    // tlast marks exactly the final step
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[130:128] == 3'd5)))
        else $error("tlast misplaced");
endmodule

### tb/sv/tb_path_reference_window_generator.sv
// Self-checking testbench of the path reference window generator.
module tb_path_reference_window_generator;
    import prwg_pkg::*;

    typedef struct {
        logic        kind;
        logic [9:0]  idx;
        logic [31:0] px, py, ph, ps, vx, vy, vs;
    } path_req_t;

    typedef struct packed {
        logic [31:0] rx, ry, rh, rs;
        logic [2:0]  step;
        logic [9:0]  near;
        logic        last;
    } ref_point_t;

    // Entries written at the start; random courses stay within them
    localparam int FILL_LEN = 40;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [239:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = 1'b0;
    logic [22:0]  cfg_data = '0;

    path_reference_window_generator dut (.*);

    always #6 aclk = ~aclk;

    // Stimulus and expectation stores
    path_req_t  pending_reqs[$];
    ref_point_t expected_points[$];
    int         fail_count = 0;
    int         mismatch_count = 0;
    bit         calm = 1'b0;
    bit         stall_armed = 1'b0;

    // Predictor copy of the block state
    logic [31:0] tbl_x[PATH_DEPTH], tbl_y[PATH_DEPTH], tbl_h[PATH_DEPTH], tbl_s[PATH_DEPTH];
    logic [9:0]  tgt_index = '0;
    logic [10:0] len_reg = 11'd1;
    logic [22:0] ips_reg = 23'd13107;

    // Generation-time copy of the table, used to aim queries near the path
    logic [31:0] gen_x[PATH_DEPTH], gen_y[PATH_DEPTH];
    int          gen_len = 1;

    function automatic logic [65:0] dist_sq(int i, logic [31:0] vx, logic [31:0] vy);
        longint dx, dy;
        logic [65:0] ax, ay;
        dx = longint'($signed(tbl_x[i])) - longint'($signed(vx));
        dy = longint'($signed(tbl_y[i])) - longint'($signed(vy));
        ax = (dx < 0) ? 66'(-dx) : 66'(dx);
        ay = (dy < 0) ? 66'(-dy) : 66'(dy);
        return ax * ax + ay * ay;
    endfunction

    // Apply one accepted item: write the table or predict the six points
    function automatic void compute_window(path_req_t r);
        int len, start, stop, best_i;
        logic [65:0] best_d, d;
        longint vabs;
        longint unsigned mag, adv, pos;
        ref_point_t p;
        if (r.kind == REQ_LOAD) begin
            tbl_x[r.idx] = r.px;
            tbl_y[r.idx] = r.py;
            tbl_h[r.idx] = r.ph;
            tbl_s[r.idx] = r.ps;
            return;
        end
        len = (len_reg == 0) ? 1 : (len_reg > PATH_DEPTH ? PATH_DEPTH : int'(len_reg));
        start = (int'(tgt_index) > len - 1) ? len - 1 : int'(tgt_index);
        stop = (start + SEARCH_WINDOW > len) ? len : start + SEARCH_WINDOW;
        best_i = start;
        best_d = dist_sq(start, r.vx, r.vy);
        for (int i = start + 1; i < stop; i++) begin
            d = dist_sq(i, r.vx, r.vy);
            if (d < best_d) begin
                best_d = d;
                best_i = i;
            end
        end
        tgt_index = best_i[9:0];
        vabs = longint'($signed(r.vs));
        if (vabs < 0) vabs = -vabs;
        mag = longint'(vabs) * longint'({41'b0, ips_reg});
        for (int k = 1; k <= HORIZON; k++) begin
            adv = (longint'(k) * mag + 64'h8000_0000) >> 32;
            pos = longint'(best_i) + adv;
            if (pos > longint'(len - 1)) pos = len - 1;
            p.rx = tbl_x[pos];
            p.ry = tbl_y[pos];
            p.rh = tbl_h[pos];
            p.rs = tbl_s[pos];
            p.step = 3'(k - 1);
            p.near = best_i[9:0];
            p.last = (k == HORIZON);
            expected_points = {expected_points, p};
        end
    endfunction

    // Track accepted transfers on the input and configuration channels
    bit in_fire = 1'b0;
    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            path_req_t r;
            r.kind = s_tuser;
            r.idx = s_tdata[9:0];
            r.px = s_tdata[41:10];
            r.py = s_tdata[73:42];
            r.ph = s_tdata[105:74];
            r.ps = s_tdata[137:106];
            r.vx = s_tdata[169:138];
            r.vy = s_tdata[201:170];
            r.vs = s_tdata[233:202];
            compute_window(r);
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == REG_COURSE_LENGTH) len_reg = cfg_data[10:0];
            else ips_reg = cfg_data;
        end
    end

    // Input driver: hold the item until its transfer, idle in random bursts
    int send_gap = 0;
    always @(negedge aclk) begin
        path_req_t r;
        logic [239:0] w;
        logic nv;
        nv = s_tvalid;
        if (!aresetn) begin
            nv = 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (send_gap > 0) begin
                nv = 1'b0;
                send_gap--;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                w = {6'b0, r.vs, r.vy, r.vx, r.ps, r.ph, r.py, r.px, r.idx};
                s_tdata <= w;
                s_tuser <= r.kind;
                nv = 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
            end else begin
                nv = 1'b0;
            end
        end
        s_tvalid <= nv;
    end

    // Result receiver: random stall bursts and one long hold-off
    int recv_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge aclk) begin
        logic rdy;
        rdy = 1'b1;
        if (!aresetn) begin
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            rdy = 1'b0;
            hold_left--;
        end else if (stall_armed && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
            rdy = 1'b0;
        end else if (recv_gap > 0) begin
            rdy = 1'b0;
            recv_gap--;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            recv_gap = $urandom_range(0, 7);
            rdy = 1'b0;
        end
        m_tready <= rdy;
    end

    // Compare each result transfer against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            logic [143:0] o;
            ref_point_t e, a;
            o = m_tdata;
            a.rx = o[31:0];
            a.ry = o[63:32];
            a.rh = o[95:64];
            a.rs = o[127:96];
            a.step = o[130:128];
            a.near = o[140:131];
            a.last = m_tlast;
            if (expected_points.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: x=%h y=%h step=%0d near=%0d",
                             a.rx, a.ry, a.step, a.near);
            end else begin
                e = expected_points.pop_front();
                if (a !== e) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp x=%h y=%h h=%h s=%h step=%0d near=%0d last=%b",
                                 e.rx, e.ry, e.rh, e.rs, e.step, e.near, e.last,
                                 "\n          got x=%h y=%h h=%h s=%h step=%0d near=%0d last=%b",
                                 a.rx, a.ry, a.rh, a.rs, a.step, a.near, a.last);
                end
            end
        end
    end

    task automatic push_load(int i, logic [31:0] x, logic [31:0] y, logic [31:0] h,
                             logic [31:0] s);
        path_req_t r;
        r.kind = REQ_LOAD;
        r.idx = i[9:0];
        r.px = x; r.py = y; r.ph = h; r.ps = s;
        r.vx = $urandom; r.vy = $urandom; r.vs = $urandom;
        gen_x[i] = x;
        gen_y[i] = y;
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic push_query(logic [31:0] x, logic [31:0] y, logic [31:0] v);
        path_req_t r;
        r.kind = REQ_QUERY;
        r.idx = 10'($urandom);
        r.px = $urandom; r.py = $urandom; r.ph = $urandom; r.ps = $urandom;
        r.vx = x; r.vy = y; r.vs = v;
        pending_reqs = {pending_reqs, r};
    endtask

    // Random item: mostly queries aimed near a path point, some loads
    task automatic push_random();
        int j;
        logic [31:0] v;
        if ($urandom_range(0, 9) < 3) begin
            push_load($urandom_range(0, PATH_DEPTH - 1), $urandom, $urandom, $urandom, $urandom);
        end else begin
            j = $urandom_range(0, gen_len - 1);
            v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h6_0000) - 32'h3_0000;
            if ($urandom_range(0, 7) == 0)
                push_query($urandom, $urandom, v);
            else
                push_query(gen_x[j] + $urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
                           gen_y[j] + $urandom_range(0, 32'h3_FFFF) - 32'h2_0000, v);
        end
    endtask

    // Wait until every item and result has moved, then let the block settle
    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [22:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_course(int len, logic [22:0] ips);
        drain();
        write_reg(REG_COURSE_LENGTH, len[22:0]);
        write_reg(REG_INDEX_PER_SPEED, ips);
        gen_len = (len == 0) ? 1 : (len > PATH_DEPTH ? PATH_DEPTH : len);
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Load the head of the path and its final entry; every read below
        // stays inside these entries
        for (int i = 0; i < FILL_LEN; i++)
            push_load(i, (i << 17) ^ ($urandom & 32'h1_FFFF),
                      ($urandom & 32'h3_FFFF) - 32'h2_0000, $urandom, $urandom);
        push_load(PATH_DEPTH - 1, $urandom, $urandom, $urandom, $urandom);

        // Reset settings: single-entry course
        push_query($urandom, $urandom, 32'h0001_0000);
        push_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);

        // Extreme coordinates, a tie between two equal entries, extreme speeds,
        // and an advance that rounds near one half
        set_course(1024, 23'h7F_FFFF);
        push_load(5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_load(6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_load(7, 32'h0012_3456, 32'hFFF0_0000, 32'h1, 32'h2);
        push_load(8, 32'h0012_3456, 32'hFFF0_0000, 32'h3, 32'h4);
        push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        push_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_query(32'h0012_3456, 32'hFFF0_0000, 32'hFFFF_FFFF);
        push_query(32'h0012_3456, 32'hFFF0_0000, 32'h0000_0100);

        // Zero length, oversize length, and a short course under an advanced target
        set_course(0, 23'd13107);
        push_query($urandom, $urandom, $urandom);
        set_course(2047, 23'h40_0000);
        push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        set_course(3, 23'h0);
        push_query($urandom, $urandom, $urandom);
        push_query(32'h0, 32'h0, 32'h8000_0000);

        // Random phases under several settings
        set_course(FILL_LEN, 23'($urandom_range(0, 23'h40_0000)));
        repeat (20) push_random();
        stall_armed = 1'b1;
        set_course(17, 23'd13107);
        repeat (15) push_random();
        set_course(24, 23'h40_0000);
        repeat (15) push_random();
        set_course(33, 23'($urandom));
        repeat (15) push_random();

        // Last part without idling
        set_course(FILL_LEN, 23'd13107);
        calm = 1'b1;
        repeat (10) push_random();

        drain();
        if (expected_points.size() > 0) fail_count++;
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #(12 * 400000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### path_reference_window_generator.f
hw/rtl/prwg_pkg.sv
hw/rtl/prwg_ram.sv
hw/rtl/prwg_front.sv
hw/rtl/prwg_back.sv
hw/rtl/path_reference_window_generator.sv
tb/sv/tb_path_reference_window_generator.sv
